/* rtl/hwc_pkg.sv */
`timescale 1ns / 1ps
// Package for the history window block: sizes, widths and op codes.
// No dependencies; imported by history_window_with_cursor.
package hwc_pkg;

  // Ring geometry
  localparam int Depth      = 256;
  localparam int AddrW      = $clog2(Depth);
  localparam int CountW     = AddrW + 1;
  localparam int EntryW     = 64;

  // Input field widths
  localparam int OpW        = 3;
  localparam int IndexW     = 8;
  localparam int CapW       = 9;

  // Op codes
  localparam logic [OpW-1:0] OpPush    = 3'd0;
  localparam logic [OpW-1:0] OpRewind  = 3'd1;
  localparam logic [OpW-1:0] OpForward = 3'd2;
  localparam logic [OpW-1:0] OpClear   = 3'd3;
  localparam logic [OpW-1:0] OpReadAt  = 3'd4;
  localparam logic [OpW-1:0] OpResize  = 3'd5;

  localparam logic [CountW-1:0] DepthCount = CountW'(Depth);

endpackage

/* rtl/history_window_with_cursor.sv */
`timescale 1ns / 1ps
// Bounded history window: ring of entries in one synchronous RAM plus cursor.
// Depends on hwc_pkg.
//
// Usage:
//  - Input channel (in_valid_i / in_stall_o) carries one op per beat: op_i,
//    payload_i, read_index_i, new_capacity_i. Output channel (out_valid_o /
//    out_stall_i) returns exactly one result beat per op.
//  - A beat moves at a rising edge with valid high and stall low.
//  - Each op steps through the accept cycle, which updates the pointers and does
//    the push write, then StRead, which issues the RAM reads (cursor entry and
//    read_at entry), then StLoad, which loads the output register once it is
//    free; out_valid_o rises when that register is loaded. The input stalls
//    until the op leaves StLoad, so a new op is taken only after the last one.
//  - The next op is accepted while a finished result still waits in the
//    output register; a new result waits in the RAM read register until the
//    output register is free, so a stalled receiver stalls the input after
//    at most one op.
//  - Reset empties the window (count, cursor, oldest pointer zero) and sets
//    the capacity to the full depth. RAM contents are not cleared; entries
//    are only read inside the count.
module history_window_with_cursor (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [hwc_pkg::OpW-1:0]        op_i,
  input  logic [hwc_pkg::EntryW-1:0]     payload_i,
  input  logic [hwc_pkg::IndexW-1:0]     read_index_i,
  input  logic [hwc_pkg::CapW-1:0]       new_capacity_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic                           ok_o,
  output logic [hwc_pkg::EntryW-1:0]     current_entry_o,
  output logic                           current_valid_o,
  output logic [hwc_pkg::AddrW-1:0]      cursor_o,
  output logic [hwc_pkg::CountW-1:0]     entry_count_o,
  output logic                           has_past_o,
  output logic                           has_future_o,
  output logic [hwc_pkg::EntryW-1:0]     read_entry_o,
  output logic                           read_error_o
);
  import hwc_pkg::*;

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StRead = 2'd1;
  localparam logic [1:0] StLoad = 2'd2;

  logic [1:0]        state_q, state_d;
  logic [AddrW-1:0]  oldest_q, oldest_d;
  logic [CountW-1:0] count_q, count_d;
  logic [AddrW-1:0]  cursor_q, cursor_d;
  logic [CountW-1:0] cap_q, cap_d;
  logic              ok_q, ok_d;
  logic              rerr_q, rerr_d;
  logic              is_read_q;
  logic [IndexW-1:0] ridx_q;

  logic [EntryW-1:0] mem [Depth];
  logic              mem_we;
  logic [AddrW-1:0]  mem_waddr;
  logic              mem_re;
  logic [EntryW-1:0] cur_rdata_q;
  logic [EntryW-1:0] idx_rdata_q;

  logic              in_acc;
  logic              out_free;
  logic              load_out;

  // Output register
  logic              out_valid_q;
  logic              ok_out_q;
  logic [EntryW-1:0] cur_entry_q;
  logic              cur_valid_q;
  logic [AddrW-1:0]  cursor_out_q;
  logic [CountW-1:0] count_out_q;
  logic              has_past_q;
  logic              has_future_q;
  logic [EntryW-1:0] read_entry_q;
  logic              read_error_q;

  // Push and resize intermediates
  logic              full;
  logic [AddrW-1:0]  push_oldest;
  logic [CountW-1:0] push_count;
  logic [AddrW-1:0]  push_cursor;
  logic [CountW-1:0] rs_cap;
  logic [CountW-1:0] rs_front;
  logic [CountW-1:0] rs_cursor;
  logic [CountW-1:0] rs_last;

  assign in_stall_o = (state_q != StIdle);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign load_out   = (state_q == StLoad) && out_free;
  assign mem_re     = (state_q == StRead);

  // Push: drop the oldest entry when full, then append
  always_comb begin
    full        = (count_q >= cap_q) && (count_q != '0);
    push_oldest = full ? oldest_q + AddrW'(1) : oldest_q;
    push_count  = full ? count_q - CountW'(1) : count_q;
    push_cursor = push_count[AddrW-1:0];
    mem_waddr   = push_oldest + push_count[AddrW-1:0];
  end

  // Resize: saturate capacity (zero becomes one), trim front up to the cursor, then the back
  always_comb begin
    if (new_capacity_i > CapW'(Depth)) begin
      rs_cap = DepthCount;
    end else if (new_capacity_i == '0) begin
      rs_cap = CountW'(1);
    end else begin
      rs_cap = CountW'(new_capacity_i);
    end
    rs_front = count_q - rs_cap;
    if (rs_front > {1'b0, cursor_q}) begin
      rs_front = {1'b0, cursor_q};
    end
    rs_cursor = {1'b0, cursor_q} - rs_front;
    rs_last   = rs_cap - CountW'(1);
    if (rs_cursor > rs_last) begin
      rs_cursor = rs_last;
    end
  end

  // Pointer update on the accept cycle
  always_comb begin
    oldest_d = oldest_q;
    count_d  = count_q;
    cursor_d = cursor_q;
    cap_d    = cap_q;
    ok_d     = 1'b1;
    rerr_d   = 1'b0;
    mem_we   = 1'b0;
    case (op_i)
      OpPush: begin
        mem_we   = 1'b1;
        oldest_d = push_oldest;
        count_d  = push_count + CountW'(1);
        cursor_d = push_cursor;
      end
      OpRewind: begin
        if (count_q != '0 && cursor_q != '0) begin
          cursor_d = cursor_q - AddrW'(1);
        end else begin
          ok_d = 1'b0;
        end
      end
      OpForward: begin
        if (count_q != '0 && ({1'b0, cursor_q} + CountW'(1)) < count_q) begin
          cursor_d = cursor_q + AddrW'(1);
        end else begin
          ok_d = 1'b0;
        end
      end
      OpClear: begin
        oldest_d = '0;
        count_d  = '0;
        cursor_d = '0;
      end
      OpReadAt: begin
        rerr_d = (CountW'(read_index_i) >= count_q);
      end
      OpResize: begin
        cap_d = rs_cap;
        if (count_q > rs_cap) begin
          oldest_d = oldest_q + rs_front[AddrW-1:0];
          count_d  = rs_cap;
          cursor_d = rs_cursor[AddrW-1:0];
        end
      end
      default: begin
      end
    endcase
  end

  // Sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: if (in_acc) state_d = StRead;
      StRead: state_d = StLoad;
      StLoad: if (out_free) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      oldest_q <= '0;
      count_q  <= '0;
      cursor_q <= '0;
      cap_q    <= DepthCount;
    end else begin
      state_q <= state_d;
      if (in_acc) begin
        oldest_q <= oldest_d;
        count_q  <= count_d;
        cursor_q <= cursor_d;
        cap_q    <= cap_d;
      end
    end
  end

  // Per-op side info
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      ok_q      <= ok_d;
      rerr_q    <= rerr_d;
      is_read_q <= (op_i == OpReadAt);
      ridx_q    <= read_index_i;
    end
  end

  // Entry RAM: one write, two registered reads
  always_ff @(posedge clk_i) begin
    if (in_acc && mem_we) begin
      mem[mem_waddr] <= payload_i;
    end
    if (mem_re) begin
      cur_rdata_q <= mem[oldest_q + cursor_q];
      idx_rdata_q <= mem[oldest_q + ridx_q];
    end
  end

  // Output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output payload
  always_ff @(posedge clk_i) begin
    if (load_out) begin
      ok_out_q     <= ok_q;
      cur_valid_q  <= (count_q != '0);
      cur_entry_q  <= (count_q != '0) ? cur_rdata_q : '0;
      cursor_out_q <= (count_q != '0) ? cursor_q : '0;
      count_out_q  <= count_q;
      has_past_q   <= (count_q != '0) && (cursor_q != '0);
      has_future_q <= (count_q != '0) && (({1'b0, cursor_q} + CountW'(1)) < count_q);
      read_entry_q <= (is_read_q && !rerr_q) ? idx_rdata_q : '0;
      read_error_q <= rerr_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign ok_o            = ok_out_q;
  assign current_entry_o = cur_entry_q;
  assign current_valid_o = cur_valid_q;
  assign cursor_o        = cursor_out_q;
  assign entry_count_o   = count_out_q;
  assign has_past_o      = has_past_q;
  assign has_future_o    = has_future_q;
  assign read_entry_o    = read_entry_q;
  assign read_error_o    = read_error_q;

`ifndef NO_ASSERTIONS
  // Count never exceeds the capacity
  assert property (@(posedge clk_i) disable iff (!rst_ni) count_q <= cap_q)
    else $error("entry count above capacity");

  // Cursor stays inside the window
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != '0) |-> ({1'b0, cursor_q} < count_q))
    else $error("cursor outside window");

  // Capacity is never zero
  assert property (@(posedge clk_i) disable iff (!rst_ni) cap_q != '0)
    else $error("capacity is zero");

  // An accepted op reaches the read stage next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q == StRead))
    else $error("accepted op did not start its read");

  // Pointers hold while an op is in flight
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != StIdle) |=> ($stable(count_q) && $stable(cursor_q) && $stable(oldest_q)))
    else $error("pointers changed during an op");
`endif

endmodule

/* verif/history_window_with_cursor_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for history_window_with_cursor: directed edge cases,
// random op mixes, ring wrap and receiver hold-off. Depends on hwc_pkg and the block.
module history_window_with_cursor_tb;
  import hwc_pkg::*;

  // Op codes the block leaves unused
  localparam logic [OpW-1:0] OpSpareLo = 3'd6;
  localparam logic [OpW-1:0] OpSpareHi = 3'd7;

  // Status of the window after one op, as the block reports it
  typedef struct packed {
    logic              ok;
    logic [EntryW-1:0] cur_entry;
    logic              cur_valid;
    logic [AddrW-1:0]  cursor;
    logic [CountW-1:0] count;
    logic              past;
    logic              future;
    logic [EntryW-1:0] rd_entry;
    logic              rd_err;
  } window_status_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_stall_o;
  logic [OpW-1:0]    op_i = '0;
  logic [EntryW-1:0] payload_i = '0;
  logic [IndexW-1:0] read_index_i = '0;
  logic [CapW-1:0]   new_capacity_i = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic              ok_o;
  logic [EntryW-1:0] current_entry_o;
  logic              current_valid_o;
  logic [AddrW-1:0]  cursor_o;
  logic [CountW-1:0] entry_count_o;
  logic              has_past_o;
  logic              has_future_o;
  logic [EntryW-1:0] read_entry_o;
  logic              read_error_o;

  history_window_with_cursor dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .op_i            (op_i),
    .payload_i       (payload_i),
    .read_index_i    (read_index_i),
    .new_capacity_i  (new_capacity_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .ok_o            (ok_o),
    .current_entry_o (current_entry_o),
    .current_valid_o (current_valid_o),
    .cursor_o        (cursor_o),
    .entry_count_o   (entry_count_o),
    .has_past_o      (has_past_o),
    .has_future_o    (has_future_o),
    .read_entry_o    (read_entry_o),
    .read_error_o    (read_error_o)
  );

  // Shadow copy of the window
  logic [EntryW-1:0] win_mem [Depth];
  int unsigned win_oldest = 0;
  int unsigned win_count = 0;
  int unsigned win_cursor = 0;
  int unsigned win_cap = Depth;

  window_status_t pending_status_q[$];
  window_status_t got_status, want_status;

  // Run controls and tallies
  bit steady_flow = 1'b0;
  int hold_off_left = 0;
  int mismatch_count = 0;
  int results_checked = 0;
  int op_tally [8];
  int refused_moves = 0;
  int read_faults = 0;
  int entries_dropped = 0;
  int unsigned peak_count = 0;

  // 100 MHz clock
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Watchdog
  initial begin
    #2ms;
    $display("history_window_with_cursor_tb NOT OK");
    $finish;
  end

  function automatic int unsigned slot_of(int unsigned pos);
    return (win_oldest + pos) % Depth;
  endfunction

  function automatic logic [EntryW-1:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  // Advance the shadow window by one op and return the status it should report
  function automatic window_status_t apply_history_op(logic [OpW-1:0] op,
                                                      logic [EntryW-1:0] data,
                                                      logic [IndexW-1:0] ridx,
                                                      logic [CapW-1:0] ncap);
    window_status_t s;
    int unsigned cap, trim;
    s = '0;
    s.ok = 1'b1;
    op_tally[op]++;
    case (op)
      OpPush: begin
        // full window: oldest entry falls out; the cursor ends on the new entry
        if (win_count >= win_cap && win_count > 0) begin
          win_oldest = (win_oldest + 1) % Depth;
          win_count--;
          entries_dropped++;
          if (win_cursor > 0) win_cursor--;
        end
        win_mem[slot_of(win_count)] = data;
        win_count++;
        win_cursor = win_count - 1;
      end
      OpRewind: begin
        if (win_count > 0 && win_cursor > 0) win_cursor--;
        else s.ok = 1'b0;
      end
      OpForward: begin
        if (win_count > 0 && win_cursor + 1 < win_count) win_cursor++;
        else s.ok = 1'b0;
      end
      OpClear: begin
        win_count = 0;
        win_cursor = 0;
        win_oldest = 0;
      end
      OpReadAt: begin
        if (ridx < win_count) s.rd_entry = win_mem[slot_of(ridx)];
        else s.rd_err = 1'b1;
      end
      OpResize: begin
        cap = ncap;
        if (cap > Depth) cap = Depth;
        if (cap < 1) cap = 1;
        win_cap = cap;
        // trim older entries up to the cursor, then newer ones
        if (win_count > cap) begin
          trim = win_count - cap;
          if (trim > win_cursor) trim = win_cursor;
          win_oldest = (win_oldest + trim) % Depth;
          win_cursor -= trim;
          entries_dropped += win_count - cap;
          win_count = cap;
          if (win_cursor > win_count - 1) win_cursor = win_count - 1;
        end
      end
      default: ;
    endcase
    if (!s.ok) refused_moves++;
    if (s.rd_err) read_faults++;
    if (win_count > peak_count) peak_count = win_count;
    s.cur_valid = (win_count > 0);
    s.count = CountW'(win_count);
    if (s.cur_valid) begin
      s.cur_entry = win_mem[slot_of(win_cursor)];
      s.cursor = AddrW'(win_cursor);
      s.past = (win_cursor > 0);
      s.future = (win_cursor + 1 < win_count);
    end
    return s;
  endfunction

  function automatic string show_status(window_status_t s);
    return $sformatf("ok=%b cur=%h v=%b pos=%0d cnt=%0d past=%b fut=%b rd=%h err=%b",
                     s.ok, s.cur_entry, s.cur_valid, s.cursor, s.count,
                     s.past, s.future, s.rd_entry, s.rd_err);
  endfunction

  task automatic report_fault(input string what);
    mismatch_count++;
    if (mismatch_count <= 10) $display("%0t: %s", $time, what);
  endtask

  // Offer an op beat after random idle cycles unless steady_flow; record its status
  task automatic send_op(input logic [OpW-1:0] op, input logic [EntryW-1:0] data,
                         input logic [IndexW-1:0] ridx, input logic [CapW-1:0] ncap);
    @(negedge clk_i);
    if (!steady_flow) begin
      while ($urandom_range(0, 99) < 34) begin
        in_valid_i = 1'b0;
        @(negedge clk_i);
      end
    end
    in_valid_i = 1'b1;
    op_i = op;
    payload_i = data;
    read_index_i = ridx;
    new_capacity_i = ncap;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pending_status_q.insert(pending_status_q.size(), apply_history_op(op, data, ridx, ncap));
  endtask

  // One random op; unused fields still carry random bits
  task automatic send_random_op(input int push_pct, input bit small_caps);
    logic [OpW-1:0] op;
    logic [IndexW-1:0] ridx;
    logic [CapW-1:0] ncap;
    int r;
    ridx = IndexW'($urandom_range(0, 255));
    ncap = CapW'($urandom_range(0, 511));
    r = $urandom_range(0, 99);
    if (r < push_pct) op = OpPush;
    else begin
      r = $urandom_range(0, 99);
      if (r < 24) op = OpRewind;
      else if (r < 48) op = OpForward;
      else if (r < 76) op = OpReadAt;
      else if (r < 92) op = OpResize;
      else if (r < 96) op = OpClear;
      else op = $urandom_range(0, 1) ? OpSpareHi : OpSpareLo;
    end
    if (op == OpReadAt && win_count > 0 && $urandom_range(0, 99) < 80)
      ridx = IndexW'($urandom_range(0, win_count - 1));
    if (op == OpResize) begin
      if (small_caps) ncap = CapW'($urandom_range(0, 12));
      else begin
        case ($urandom_range(0, 9))
          0: ncap = '0;
          1: ncap = CapW'($urandom_range(Depth, 511));
          2: ncap = CapW'(Depth);
          3, 4, 5: ncap = CapW'($urandom_range(1, 16));
          6, 7: ncap = (win_count > 0) ? CapW'($urandom_range(1, win_count)) : CapW'(1);
          default: ncap = CapW'($urandom_range(0, 511));
        endcase
      end
    end
    send_op(op, rand_word(), ridx, ncap);
  endtask

  // Result checker
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got_status = '{ok_o, current_entry_o, current_valid_o, cursor_o, entry_count_o,
                     has_past_o, has_future_o, read_entry_o, read_error_o};
      if (pending_status_q.size() == 0) begin
        report_fault({"result beat with none expected: ", show_status(got_status)});
      end else begin
        want_status = pending_status_q[0];
        pending_status_q.delete(0);
        results_checked++;
        if (got_status !== want_status)
          report_fault({"status mismatch\n  exp ", show_status(want_status),
                        "\n  got ", show_status(got_status)});
      end
    end
  end

  // Receiver stall: random, steady, or a counted hold-off
  always @(negedge clk_i) begin
    if (hold_off_left > 0) begin
      out_stall_i = 1'b1;
      hold_off_left = hold_off_left - 1;
    end else if (steady_flow) begin
      out_stall_i = 1'b0;
    end else begin
      out_stall_i = ($urandom_range(0, 99) < 34);
    end
  end

  // Empty window, field extremes, cursor limits, resize corners, spare codes
  task automatic test_directed_edges();
    send_op(OpRewind, '0, '0, '0);
    send_op(OpForward, '1, '1, '1);
    send_op(OpReadAt, '0, 8'd0, '0);
    send_op(OpReadAt, '1, 8'd255, '1);
    send_op(OpSpareLo, '1, '1, '1);
    send_op(OpSpareHi, '0, '0, '0);
    send_op(OpPush, '0, '1, '1);
    send_op(OpPush, '1, '0, '0);
    send_op(OpPush, 64'h5A5A_C3C3_0F0F_9696, '0, '0);
    send_op(OpReadAt, '0, 8'd0, '0);
    send_op(OpReadAt, '0, 8'd2, '0);
    send_op(OpReadAt, '0, 8'd3, '0);
    repeat (3) send_op(OpRewind, '0, '0, '0);
    repeat (3) send_op(OpForward, '0, '0, '0);
    // capacity of zero becomes one; cursor keeps the newest entry
    send_op(OpResize, '0, '0, 9'd0);
    send_op(OpPush, 64'h0123_4567_89AB_CDEF, '0, '0);
    send_op(OpReadAt, '0, 8'd0, '0);
    // above the depth saturates
    send_op(OpResize, '0, '0, 9'd511);
    send_op(OpPush, 64'hFEDC_BA98_7654_3210, '0, '0);
    send_op(OpResize, '0, '0, CapW'(Depth));
    send_op(OpClear, '0, '0, '0);
    send_op(OpReadAt, '0, 8'd0, '0);
    send_op(OpForward, '0, '0, '0);
  endtask

  // Small capacities keep the window full so evictions and trims are frequent
  task automatic test_small_capacity(input int n);
    send_op(OpResize, rand_word(), '0, 9'd4);
    repeat (n) send_random_op(50, 1'b1);
  endtask

  // Fill the whole ring past its depth, then trim from the front and from the back
  task automatic test_full_ring_wrap();
    int i;
    send_op(OpResize, rand_word(), '0, CapW'(Depth));
    send_op(OpClear, rand_word(), '0, '0);
    steady_flow = 1'b1;
    for (i = 0; i < 280; i++) begin
      if (i == 150) steady_flow = 1'b0;
      if (i % 16 == 15)
        send_op(OpReadAt, rand_word(), IndexW'($urandom_range(0, win_count - 1)), '0);
      send_op(OpPush, rand_word(), IndexW'($urandom_range(0, 255)),
              CapW'($urandom_range(0, 511)));
    end
    repeat (30) send_op(OpRewind, rand_word(), '0, '0);
    send_op(OpResize, rand_word(), '0, CapW'($urandom_range(64, 200)));
    repeat (60) send_op(OpRewind, rand_word(), '0, '0);
    send_op(OpResize, rand_word(), '0, CapW'($urandom_range(20, 60)));
    repeat (6) send_op(OpReadAt, rand_word(), IndexW'($urandom_range(0, 63)), '0);
  endtask

  // Receiver holds off while the sender keeps offering beats
  task automatic test_receiver_hold_off();
    steady_flow = 1'b1;
    send_op(OpPush, rand_word(), '0, '0);
    hold_off_left = 200;
    repeat (40) send_random_op(50, 1'b0);
    steady_flow = 1'b0;
  endtask

  task automatic test_random_mix(input int n);
    repeat (n) send_random_op(40, 1'b0);
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed_edges();
    test_small_capacity(220);
    test_full_ring_wrap();
    test_receiver_hold_off();
    test_random_mix(230);

    // drain
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (pending_status_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    $display("Ran %0d pushes, %0d rewinds, %0d forwards, %0d reads, %0d resizes, %0d clears;",
             op_tally[OpPush], op_tally[OpRewind], op_tally[OpForward],
             op_tally[OpReadAt], op_tally[OpResize], op_tally[OpClear]);
    $display("  %0d refused moves, %0d bad reads, %0d entries dropped, peak %0d, %0d checked.",
             refused_moves, read_faults, entries_dropped, peak_count, results_checked);
    if (mismatch_count == 0) begin
      $display("history_window_with_cursor_tb OK");
    end else begin
      $display("%0d mismatches", mismatch_count);
      $display("history_window_with_cursor_tb NOT OK");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/hwc_pkg.sv
rtl/history_window_with_cursor.sv
verif/history_window_with_cursor_tb.sv
